@@ rtl/core/mkt_pkg.sv @@
`default_nettype none
package mkt_pkg;

    localparam int CAPACITY    = 16;
    localparam int ENTRY_BYTES = 8;
    localparam int SLOT_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int DATA_W      = 64;
    localparam int LEN_W       = 4;
    localparam int CAP_REG_W   = 5;
    localparam int KIND_W      = 3;
    localparam int STAT_W      = 2;

    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FIND   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GET    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS      = 2'd1;
    localparam logic [STAT_W-1:0] ST_SMALL_BUF = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_POS   = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] entry_data;
        logic [LEN_W-1:0]  entry_length;
        logic [SLOT_W-1:0] position;
    } t_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] found_position;
        logic [DATA_W-1:0] out_data;
        logic [LEN_W-1:0]  out_length;
    } t_result;

    typedef struct packed {
        logic load;
        logic scan;
        logic rd_pos;
        logic act;
    } t_ctl_cmd;

    typedef struct packed {
        logic scan_done;
    } t_ctl_stat;

    function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int b = 0; b < DATA_W / 8; b++) begin
            if (LEN_W'(b) < len) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/mru_keyed_table.sv @@
// add and find walk the list one position a cycle until a match or the end
// of the used list; then the act state registers the result and the strobe
// get, query and delete read the position before act, unknown kinds go to act
// one item at a time; the next start is taken in the cycle of the strobe
// synchronous reset empties the list, frees all slots and sets capacity to 16
`default_nettype none
module mru_keyed_table (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire mkt_pkg::t_item                i_item,
    input  wire logic                          i_cfg_we,
    input  wire logic [mkt_pkg::CAP_REG_W-1:0] i_cfg_wdata,
    output logic                               o_strobe,
    output mkt_pkg::t_result                   o_result
);
    import mkt_pkg::*;

    t_ctl_cmd  cmd;
    t_ctl_stat stat;

    mkt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_item.kind),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    mkt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule
`default_nettype wire

@@ rtl/core/mkt_ctrl.sv @@
`default_nettype none
module mkt_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [mkt_pkg::KIND_W-1:0] i_kind,
    input  wire mkt_pkg::t_ctl_stat        i_stat,
    output mkt_pkg::t_ctl_cmd              o_cmd,
    output logic                           o_busy
);
    import mkt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_ACT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    case (i_kind) inside
                        KIND_ADD, KIND_FIND:                n_state = S_SCAN;
                        KIND_GET, KIND_QUERY, KIND_DELETE:  n_state = S_READ;
                        default:                            n_state = S_ACT;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_ACT;
                end
            end
            S_READ: begin
                o_cmd.rd_pos = 1'b1;
                n_state      = S_ACT;
            end
            S_ACT: begin
                o_cmd.act = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

@@ rtl/core/mkt_dpath.sv @@
`default_nettype none
module mkt_dpath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire mkt_pkg::t_ctl_cmd            i_cmd,
    output mkt_pkg::t_ctl_stat                o_stat,
    input  wire mkt_pkg::t_item               i_item,
    input  wire logic                         i_cfg_we,
    input  wire logic [mkt_pkg::CAP_REG_W-1:0] i_cfg_wdata,
    output logic                              o_strobe,
    output mkt_pkg::t_result                  o_result
);
    import mkt_pkg::*;

    // configuration and stored list
    logic [CAP_REG_W-1:0] r_cap;
    logic [SLOT_W-1:0]    r_order [CAPACITY];
    logic [SLOT_W-1:0]    n_order [CAPACITY];
    logic [CNT_W-1:0]     r_used;
    logic [CNT_W-1:0]     n_used;
    logic [CAPACITY-1:0]  r_taken;
    logic [CAPACITY-1:0]  n_taken;

    // entry storage
    logic [DATA_W-1:0] mem_bytes [CAPACITY];
    logic [LEN_W-1:0]  mem_len   [CAPACITY];
    logic [DATA_W-1:0] r_rd_bytes;
    logic [LEN_W-1:0]  r_rd_len;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_wa;

    // latched item
    logic [KIND_W-1:0] r_kind;
    logic [DATA_W-1:0] r_data;
    logic [LEN_W-1:0]  r_len;
    logic [SLOT_W-1:0] r_pos;
    logic [LEN_W-1:0]  ld_len;

    // scan pipeline
    logic [CNT_W-1:0]  r_scan_p;
    logic              r_cmp_v;
    logic [SLOT_W-1:0] r_cmp_p;
    logic [SLOT_W-1:0] r_sel_s;
    logic              r_pos_ok;
    logic              r_hit;
    logic [SLOT_W-1:0] r_hit_p;
    logic [SLOT_W-1:0] r_hit_s;
    logic              match;
    logic              issue_v;

    logic [CNT_W-1:0]  eff_cap;
    logic [CNT_W-1:0]  used_m1;
    logic [SLOT_W-1:0] order_ra;
    logic [SLOT_W-1:0] order_rd;
    logic              slot_ok;

    logic              free_found;
    logic [SLOT_W-1:0] free_s;

    logic              front_en;
    logic [CNT_W-1:0]  front_p;
    logic [SLOT_W-1:0] front_s;
    logic              back_en;

    t_result           n_res;
    t_result           r_res;
    logic              r_strobe;

    assign eff_cap = (r_cap > CAP_REG_W'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(r_cap);
    assign used_m1 = r_used - CNT_W'(1);

    always_comb begin
        if (i_cmd.scan) begin
            order_ra = r_scan_p[SLOT_W-1:0];
        end else if (i_cmd.rd_pos) begin
            order_ra = r_pos;
        end else begin
            order_ra = used_m1[SLOT_W-1:0];
        end
    end

    assign order_rd = r_order[order_ra];
    assign slot_ok  = (CNT_W'(order_rd) < eff_cap);
    assign issue_v  = (r_scan_p < r_used) && slot_ok;
    assign match    = r_cmp_v && (r_rd_len == r_len) && (r_rd_bytes == r_data);
    assign o_stat.scan_done = match || (r_scan_p >= r_used);

    always_comb begin
        if (((i_item.kind == KIND_ADD) || (i_item.kind == KIND_FIND))
            && (i_item.entry_length > LEN_W'(ENTRY_BYTES))) begin
            ld_len = LEN_W'(ENTRY_BYTES);
        end else begin
            ld_len = i_item.entry_length;
        end
    end

    // lowest free slot below the effective capacity
    always_comb begin
        free_found = 1'b0;
        free_s     = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_taken[i] && (CNT_W'(i) < eff_cap)) begin
                free_found = 1'b1;
                free_s     = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_res    = '0;
        front_en = 1'b0;
        front_p  = '0;
        front_s  = '0;
        back_en  = 1'b0;
        mem_we   = 1'b0;
        mem_wa   = '0;
        n_used   = r_used;
        n_taken  = r_taken;
        if (i_cmd.act) begin
            case (r_kind)
                KIND_ADD: begin
                    if (r_hit) begin
                        front_en   = 1'b1;
                        front_p    = CNT_W'(r_hit_p);
                        front_s    = r_hit_s;
                        n_res.slot = r_hit_s;
                    end else if (free_found) begin
                        n_taken[free_s] = 1'b1;
                        front_en   = 1'b1;
                        front_p    = r_used;
                        front_s    = free_s;
                        n_used     = r_used + CNT_W'(1);
                        mem_we     = 1'b1;
                        mem_wa     = free_s;
                        n_res.slot = free_s;
                    end else if (r_used == '0) begin
                        n_res.status = ST_MISS;
                    end else begin
                        front_en   = 1'b1;
                        front_p    = used_m1;
                        front_s    = order_rd;
                        mem_we     = 1'b1;
                        mem_wa     = order_rd;
                        n_res.slot = order_rd;
                    end
                end
                KIND_FIND: begin
                    if (r_hit) begin
                        n_res.found_position = r_hit_p;
                    end else begin
                        n_res.status = ST_MISS;
                    end
                end
                KIND_GET, KIND_QUERY, KIND_DELETE: begin
                    if (!r_pos_ok) begin
                        n_res.status = ST_BAD_POS;
                    end else begin
                        n_res.slot = r_sel_s;
                        if (r_kind == KIND_GET) begin
                            n_res.out_length = r_rd_len;
                            if (r_len < r_rd_len) begin
                                n_res.status = ST_SMALL_BUF;
                            end else begin
                                n_res.out_data = r_rd_bytes;
                            end
                        end else if (r_kind == KIND_QUERY) begin
                            n_res.out_length = r_rd_len;
                        end else begin
                            back_en          = 1'b1;
                            n_used           = used_m1;
                            n_taken[r_sel_s] = 1'b0;
                        end
                    end
                end
                default: begin
                    n_res.status = ST_MISS;
                end
            endcase
        end
    end

    always_comb begin
        n_order = r_order;
        if (front_en) begin
            n_order[0] = front_s;
            for (int i = 1; i < CAPACITY; i++) begin
                if (CNT_W'(i) <= front_p) begin
                    n_order[i] = r_order[i-1];
                end
            end
        end
        if (back_en) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if ((CNT_W'(i) >= CNT_W'(r_pos)) && (CNT_W'(i + 1) < r_used)) begin
                    n_order[i] = r_order[i+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_order <= n_order;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_bytes[mem_wa] <= r_data;
            mem_len[mem_wa]   <= r_len;
        end
        r_rd_bytes <= mem_bytes[order_rd];
        r_rd_len   <= mem_len[order_rd];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_item.kind;
            r_data <= i_item.entry_data & byte_mask(ld_len);
            r_len  <= ld_len;
            r_pos  <= i_item.position;
        end
        if (i_cmd.scan) begin
            r_cmp_p <= r_scan_p[SLOT_W-1:0];
            r_sel_s <= order_rd;
            if (o_stat.scan_done) begin
                r_hit_p <= r_cmp_p;
                r_hit_s <= r_sel_s;
            end
        end
        if (i_cmd.rd_pos) begin
            r_sel_s  <= order_rd;
            r_pos_ok <= (CNT_W'(r_pos) < r_used) && slot_ok;
        end
        if (i_cmd.act) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAP_REG_W'(CAPACITY);
            r_used   <= '0;
            r_taken  <= '0;
            r_scan_p <= '0;
            r_cmp_v  <= 1'b0;
            r_hit    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_used   <= n_used;
            r_taken  <= n_taken;
            r_strobe <= i_cmd.act;
            if (i_cmd.load) begin
                r_scan_p <= '0;
                r_cmp_v  <= 1'b0;
                r_hit    <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_v <= issue_v;
                if (r_scan_p < r_used) begin
                    r_scan_p <= r_scan_p + CNT_W'(1);
                end
                if (o_stat.scan_done) begin
                    r_hit <= match;
                end
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none
module tb_top;
    import mkt_pkg::*;

    localparam int MAX_CYCLES      = 400000;
    localparam int DRAIN_WAIT      = CAPACITY + 8;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int KEYS            = 24;
    localparam int SHOW_LIMIT      = 10;

    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_MID = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

    class recency_scoreboard;
        logic [CAP_REG_W-1:0] cap_reg;
        logic [SLOT_W-1:0]    order_list[CAPACITY];
        int unsigned          n_used;
        bit                   slot_used[CAPACITY];
        logic [DATA_W-1:0]    slot_data[CAPACITY];
        logic [LEN_W-1:0]     slot_len[CAPACITY];
        t_result              expected_results[$];
        int                   errors;
        int                   checked;
        int                   noted;

        function new();
            cap_reg = CAP_REG_W'(CAPACITY);
            n_used  = 0;
            errors  = 0;
            checked = 0;
            noted   = 0;
            foreach (slot_used[i]) begin
                slot_used[i]  = 1'b0;
                order_list[i] = '0;
                slot_data[i]  = '0;
                slot_len[i]   = '0;
            end
        endfunction

        function int unsigned eff_cap();
            return (cap_reg > CAPACITY) ? CAPACITY : int'(cap_reg);
        endfunction

        function logic [DATA_W-1:0] len_mask(int unsigned len);
            if (len >= ENTRY_BYTES) begin
                return '1;
            end
            return (DATA_W'(1) << (len * 8)) - DATA_W'(1);
        endfunction

        function bit pos_ok(int unsigned p);
            return p < n_used && p < CAPACITY && order_list[p] < eff_cap();
        endfunction

        function void move_front(int unsigned p, logic [SLOT_W-1:0] s);
            for (int unsigned i = p; i > 0; i--) begin
                order_list[i] = order_list[i-1];
            end
            order_list[0] = s;
        endfunction

        function bit locate(logic [DATA_W-1:0] d, logic [LEN_W-1:0] len,
                            output int unsigned where);
            where = 0;
            for (int unsigned p = 0; p < n_used; p++) begin
                if (pos_ok(p) && slot_len[order_list[p]] == len &&
                    slot_data[order_list[p]] == d) begin
                    where = p;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function t_result predict(t_item it);
            t_result           r;
            logic [LEN_W-1:0]  len;
            logic [DATA_W-1:0] d;
            int unsigned       p;
            int unsigned       s;
            int unsigned       cap;
            r   = '0;
            len = it.entry_length;
            if ((it.kind == KIND_ADD || it.kind == KIND_FIND) && len > ENTRY_BYTES) begin
                len = LEN_W'(ENTRY_BYTES);
            end
            d = it.entry_data & len_mask(len);
            case (it.kind)
                KIND_ADD: begin
                    if (locate(d, len, p)) begin
                        s = order_list[p];
                        move_front(p, SLOT_W'(s));
                        r.slot = SLOT_W'(s);
                    end else begin
                        cap = eff_cap();
                        s = 0;
                        while (s < cap && slot_used[s]) begin
                            s++;
                        end
                        if (s < cap) begin
                            slot_used[s] = 1'b1;
                            move_front(n_used, SLOT_W'(s));
                            n_used++;
                        end else if (n_used == 0) begin
                            r.status = ST_MISS;
                        end else begin
                            s = order_list[n_used-1];
                            move_front(n_used - 1, SLOT_W'(s));
                        end
                        if (r.status == ST_OK) begin
                            slot_data[s] = d;
                            slot_len[s]  = len;
                            r.slot       = SLOT_W'(s);
                        end
                    end
                end
                KIND_FIND: begin
                    if (locate(d, len, p)) begin
                        r.found_position = SLOT_W'(p);
                    end else begin
                        r.status = ST_MISS;
                    end
                end
                KIND_GET, KIND_QUERY, KIND_DELETE: begin
                    if (!pos_ok(it.position)) begin
                        r.status = ST_BAD_POS;
                    end else begin
                        s = order_list[it.position];
                        r.slot = SLOT_W'(s);
                        if (it.kind == KIND_GET) begin
                            r.out_length = slot_len[s];
                            if (it.entry_length < slot_len[s]) begin
                                r.status = ST_SMALL_BUF;
                            end else begin
                                r.out_data = slot_data[s];
                            end
                        end else if (it.kind == KIND_QUERY) begin
                            r.out_length = slot_len[s];
                        end else begin
                            for (p = it.position; p + 1 < n_used; p++) begin
                                order_list[p] = order_list[p+1];
                            end
                            n_used--;
                            slot_used[s] = 1'b0;
                        end
                    end
                end
                default: begin
                    r.status = ST_MISS;
                end
            endcase
            return r;
        endfunction

        function void note_item(t_item it);
            expected_results.push_back(predict(it));
            noted++;
        endfunction

        function void check_result(t_result got);
            t_result want;
            checked++;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= SHOW_LIMIT) begin
                    $display("result %0d with nothing expected: status %0d slot %0d pos %0d",
                             checked, got.status, got.slot, got.found_position);
                end
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.slot !== want.slot ||
                got.found_position !== want.found_position ||
                got.out_data !== want.out_data || got.out_length !== want.out_length) begin
                errors++;
                if (errors <= SHOW_LIMIT) begin
                    $display("result %0d expected: status %0d slot %0d pos %0d data %h len %0d",
                             checked, want.status, want.slot, want.found_position,
                             want.out_data, want.out_length);
                    $display("result %0d actual:   status %0d slot %0d pos %0d data %h len %0d",
                             checked, got.status, got.slot, got.found_position,
                             got.out_data, got.out_length);
                end
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_item                i_item;
    logic                 i_cfg_we;
    logic [CAP_REG_W-1:0] i_cfg_wdata;
    logic                 o_strobe;
    t_result              o_result;

    recency_scoreboard    sb;
    int                   idle_pct;
    int                   cycle_count;
    logic [DATA_W-1:0]    key_data[KEYS];
    logic [LEN_W-1:0]     key_len[KEYS];

    int phase_cap[PHASES]   = '{16, 1, 0, 31, 5, 0, 17, 2, 16};
    bit phase_clear[PHASES] = '{0, 0, 1, 0, 0, 0, 0, 0, 0};
    int idle_choice[3]      = '{0, 57, 36};

    mru_keyed_table uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_result(o_result);
        end
    end

    function automatic t_item make_op(logic [KIND_W-1:0] k, logic [DATA_W-1:0] d,
                                      logic [LEN_W-1:0] n, logic [SLOT_W-1:0] p);
        t_item it;
        it.kind         = k;
        it.entry_data   = d;
        it.entry_length = n;
        it.position     = p;
        return it;
    endfunction

    function automatic t_item random_op();
        t_item       it;
        int          k;
        int unsigned pick;
        it.entry_data   = {$urandom, $urandom};
        it.entry_length = LEN_W'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 36) begin
            it.kind = KIND_ADD;
        end else if (pick < 56) begin
            it.kind = KIND_FIND;
        end else if (pick < 70) begin
            it.kind = KIND_GET;
        end else if (pick < 80) begin
            it.kind = KIND_QUERY;
        end else if (pick < 94) begin
            it.kind = KIND_DELETE;
        end else begin
            it.kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        end
        // keys from a small pool so matches happen, junk in the ignored bytes
        if ((it.kind == KIND_ADD || it.kind == KIND_FIND) && $urandom_range(0, 9) < 8) begin
            k = $urandom_range(0, KEYS - 1);
            it.entry_length = key_len[k];
            it.entry_data   = key_data[k] ^ (it.entry_data & ~sb.len_mask(key_len[k]));
        end
        if (it.kind == KIND_GET && $urandom_range(0, 1) == 1) begin
            it.entry_length = LEN_W'($urandom_range(ENTRY_BYTES, 15));
        end
        if ($urandom_range(0, 3) != 0) begin
            it.position = SLOT_W'($urandom_range(0, sb.n_used > 0 ? sb.n_used - 1 : 0));
        end else begin
            it.position = SLOT_W'($urandom_range(0, 15));
        end
        return it;
    endfunction

    task automatic send_item(t_item it);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_item(it);
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_REG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.cap_reg = v;
    endtask

    task automatic empty_list();
        write_capacity(CAP_REG_W'(CAPACITY));
        repeat (CAPACITY) send_item(make_op(KIND_DELETE, '0, '0, '0));
        drain();
    endtask

    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        idle_pct    = 0;
        foreach (key_data[k]) begin
            key_data[k] = {$urandom, $urandom};
            key_len[k]  = LEN_W'($urandom_range(0, 15));
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty list, unknown kinds, long entries, matches and buffer sizes
        send_item(make_op(KIND_FIND, '0, 4'd0, 4'd0));
        send_item(make_op(KIND_GET, '1, 4'd8, 4'd0));
        send_item(make_op(KIND_QUERY, '0, 4'd0, 4'd15));
        send_item(make_op(KIND_DELETE, '1, 4'd15, 4'd0));
        send_item(make_op(KIND_UNUSED_LO, '1, 4'd15, 4'd15));
        send_item(make_op(KIND_ADD, '1, 4'd0, 4'd0));
        send_item(make_op(KIND_ADD, '1, 4'd8, 4'd0));
        send_item(make_op(KIND_ADD, 64'h0123_4567_89ab_cdef, 4'd12, 4'd0));
        send_item(make_op(KIND_ADD, 64'hdead_beef_00ab_cdef, 4'd3, 4'd0));
        send_item(make_op(KIND_ADD, '1, 4'd8, 4'd0));
        send_item(make_op(KIND_FIND, 64'h1111_1111_11ab_cdef, 4'd3, 4'd0));
        send_item(make_op(KIND_FIND, 64'h0123_4567_89ab_cdef, 4'd15, 4'd0));
        send_item(make_op(KIND_FIND, '0, 4'd1, 4'd0));
        send_item(make_op(KIND_GET, '0, 4'd8, 4'd0));
        send_item(make_op(KIND_GET, '0, 4'd2, 4'd1));
        send_item(make_op(KIND_GET, '0, 4'd0, 4'd3));
        send_item(make_op(KIND_QUERY, '0, 4'd0, 4'd2));
        send_item(make_op(KIND_DELETE, '0, 4'd0, 4'd1));
        send_item(make_op(KIND_UNUSED_MID, '0, 4'd0, 4'd0));
        send_item(make_op(KIND_ADD, 64'h5555_5555_5555_5555, 4'd0, 4'd0));
        send_item(make_op(KIND_FIND, '0, 4'd0, 4'd0));
        send_item(make_op(KIND_DELETE, '0, 4'd0, 4'd3));
        send_item(make_op(KIND_GET, '1, 4'd15, 4'd0));
        send_item(make_op(KIND_UNUSED_HI, '0, 4'd0, 4'd0));
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (phase_clear[ph]) begin
                empty_list();
            end
            write_capacity(CAP_REG_W'(phase_cap[ph]));
            idle_pct = idle_choice[ph % 3];
            repeat (ITEMS_PER_PHASE) send_item(random_op());
            drain();
        end

        $display("ran %0d operations through %0d capacity settings from 0 to 31",
                 sb.noted, PHASES + 1);
        $display("checked %0d results, %0d failed", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < MAX_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
